FILE: hdl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // fixed field widths
  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int BSIZE_W = 33;
  localparam int STAT_W  = 3;

  localparam int DEF_MAX_BLOCKS   = 16;
  localparam int DEF_ADDRESS_BITS = 48;

  localparam logic [ADDR_W-1:0]  HEAP_START_RST = 48'h0000_0040_0000;
  localparam logic [ADDR_W-1:0]  HEAP_LIMIT_RST = 48'h0000_0080_0000;
  localparam logic [BSIZE_W-1:0] HEADER_BYTES   = 33'd24;
  localparam logic [BSIZE_W-1:0] ALIGN_ADD      = 33'd15;
  localparam logic [BSIZE_W-1:0] ALIGN_MASK     = ~ALIGN_ADD;

  // request modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ALLOCATED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_OUT_OF_MEMORY = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_RELEASED      = 3'd4;
  localparam logic [STAT_W-1:0] ST_IGNORED       = 3'd5;

  // configuration register indexes
  localparam logic [0:0] CFG_HEAP_START = 1'b0;
  localparam logic [0:0] CFG_HEAP_LIMIT = 1'b1;

  // source of the returned user address
  typedef enum logic [1:0] {
    ASEL_ZERO,
    ASEL_ENTRY,
    ASEL_BREAK,
    ASEL_ECHO
  } ffba_asel_t;

  typedef struct packed {
    logic              load;
    logic              rd;
    logic              wr_flip;
    logic              append;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
    ffba_asel_t        res_sel;
  } ffba_cmd_t;

  typedef struct packed {
    logic mode;
    logic zero_req;
    logic scan_empty;
    logic hit;
    logic oom;
    logic full;
  } ffba_sts_t;

endpackage

`default_nettype wire

FILE: hdl/ffba_req_if.sv
`default_nettype none

interface ffba_req_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, output mode, output request_size, output release_address,
                  input ready);
  modport sink (input valid, input mode, input request_size, input release_address,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/ffba_rsp_if.sv
`default_nettype none

interface ffba_rsp_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] user_address;
  logic [STAT_W-1:0] status;

  modport source (output valid, output user_address, output status, input ready);
  modport sink (input valid, input user_address, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/ffba_dp.sv
`default_nettype none

module ffba_dp #(
  parameter int MAX_BLOCKS   = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffba_pkg::ffba_cmd_t            cmd,
  output ffba_pkg::ffba_sts_t            sts,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           req_mode,
  input  logic [ffba_pkg::SIZE_W-1:0]    req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]    req_addr,
  output logic [ffba_pkg::ADDR_W-1:0]    res_user_address,
  output logic [ffba_pkg::STAT_W-1:0]    res_status
);
  import ffba_pkg::*;

  localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int NW = ((AW > BSIZE_W) ? AW : BSIZE_W) + 2;
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = AW + BSIZE_W + 1;

  logic [AW-1:0]      heap_start_r, heap_start_nxt;
  logic [AW-1:0]      heap_limit_r, heap_limit_nxt;
  logic [AW-1:0]      break_r, break_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      left_r, left_nxt;

  logic               mode_r;
  logic               zero_r;
  logic [BSIZE_W-1:0] need_r;
  logic [ADDR_W-1:0]  rel_addr_r;
  logic [AW-1:0]      rd_base_r;
  logic [BSIZE_W-1:0] rd_size_r;
  logic               rd_free_r;
  logic [ADDR_W-1:0]  user_addr_r, user_addr_nxt;
  logic [STAT_W-1:0]  status_r;

  logic [EW-1:0]      blk_mem_r [MAX_BLOCKS];

  logic [BSIZE_W-1:0] need_nxt;
  logic [CW-1:0]      left_m1;
  logic [NW-1:0]      new_end;
  logic [AW-1:0]      entry_uaddr;
  logic [AW-1:0]      break_uaddr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;

  // round up to a multiple of 16
  assign need_nxt    = ({1'b0, req_size} + ALIGN_ADD) & ALIGN_MASK;
  assign left_m1     = left_r - CW'(1);
  assign new_end     = NW'(break_r) + NW'(HEADER_BYTES) + NW'(need_r);
  assign entry_uaddr = rd_base_r + AW'(HEADER_BYTES);
  assign break_uaddr = break_r + AW'(HEADER_BYTES);

  assign sts.mode       = mode_r;
  assign sts.zero_req   = zero_r;
  assign sts.scan_empty = (left_r == '0);
  assign sts.oom        = (new_end > NW'(heap_limit_r));
  assign sts.full       = (count_r == CW'(MAX_BLOCKS));
  assign sts.hit        = (mode_r == MODE_RELEASE) ? (ADDR_W'(entry_uaddr) == rel_addr_r)
                                                   : (rd_free_r && (rd_size_r >= need_r));

  always_comb begin
    heap_start_nxt = heap_start_r;
    heap_limit_nxt = heap_limit_r;
    break_nxt      = break_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_START: begin
          heap_start_nxt = cfg_data[AW-1:0];
          if (count_r == '0) begin
            break_nxt = cfg_data[AW-1:0];
          end
        end
        CFG_HEAP_LIMIT: heap_limit_nxt = cfg_data[AW-1:0];
        default: ;
      endcase
    end
    if (cmd.append) begin
      break_nxt = new_end[AW-1:0];
      count_nxt = count_r + CW'(1);
    end
    if (cmd.load) begin
      left_nxt = count_r;
    end else if (cmd.rd) begin
      left_nxt = left_m1;
    end
  end

  always_comb begin
    case (cmd.res_sel)
      ASEL_ZERO:  user_addr_nxt = '0;
      ASEL_ENTRY: user_addr_nxt = ADDR_W'(entry_uaddr);
      ASEL_BREAK: user_addr_nxt = ADDR_W'(break_uaddr);
      ASEL_ECHO:  user_addr_nxt = rel_addr_r;
      default:    user_addr_nxt = '0;
    endcase
  end

  // new entries are appended at the count, flips go back to the entry just read
  assign wr_en   = cmd.append || cmd.wr_flip;
  assign wr_addr = cmd.append ? count_r[IW-1:0] : left_r[IW-1:0];
  assign wr_data = cmd.append ? {break_r, need_r, 1'b0} : {rd_base_r, rd_size_r, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= HEAP_START_RST[AW-1:0];
      heap_limit_r <= HEAP_LIMIT_RST[AW-1:0];
      break_r      <= HEAP_START_RST[AW-1:0];
      count_r      <= '0;
      left_r       <= '0;
    end else begin
      heap_start_r <= heap_start_nxt;
      heap_limit_r <= heap_limit_nxt;
      break_r      <= break_nxt;
      count_r      <= count_nxt;
      left_r       <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= req_mode;
      zero_r     <= (req_mode == MODE_RELEASE) ? (req_addr == '0) : (req_size == '0);
      need_r     <= need_nxt;
      rel_addr_r <= req_addr;
    end
    if (cmd.res_load) begin
      user_addr_r <= user_addr_nxt;
      status_r    <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      {rd_base_r, rd_size_r, rd_free_r} <= blk_mem_r[left_m1[IW-1:0]];
    end
  end

  assign res_user_address = user_addr_r;
  assign res_status       = status_r;

endmodule

`default_nettype wire

FILE: hdl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::ffba_cmd_t cmd,
  input  ffba_pkg::ffba_sts_t sts
);
  import ffba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TEST,
    S_FINISH
  } state_t;

  state_t            st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] fin_status_r, fin_status_nxt;
  ffba_asel_t        fin_sel_r, fin_sel_nxt;
  logic              fin_append_r, fin_append_nxt;
  logic              fin_flip_r, fin_flip_nxt;

  always_comb begin
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    fin_status_nxt = fin_status_r;
    fin_sel_nxt    = fin_sel_r;
    fin_append_nxt = fin_append_r;
    fin_flip_nxt   = fin_flip_r;
    cmd            = '0;
    cmd.res_sel    = ASEL_ZERO;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        fin_append_nxt = 1'b0;
        fin_flip_nxt   = 1'b0;
        fin_sel_nxt    = ASEL_ZERO;
        if (sts.zero_req) begin
          fin_status_nxt = (sts.mode == MODE_RELEASE) ? ST_IGNORED : ST_ZERO_SIZE;
          st_nxt         = S_FINISH;
        end else begin
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_empty) begin
          st_nxt = S_FINISH;
          if (sts.mode == MODE_RELEASE) begin
            fin_status_nxt = ST_IGNORED;
          end else if (sts.oom) begin
            fin_status_nxt = ST_OUT_OF_MEMORY;
          end else if (sts.full) begin
            fin_status_nxt = ST_TABLE_FULL;
          end else begin
            // nothing free fits: grow at the break
            fin_status_nxt = ST_ALLOCATED;
            fin_sel_nxt    = ASEL_BREAK;
            fin_append_nxt = 1'b1;
          end
        end else begin
          cmd.rd = 1'b1;
          st_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.hit) begin
          st_nxt       = S_FINISH;
          fin_flip_nxt = 1'b1;
          if (sts.mode == MODE_RELEASE) begin
            fin_status_nxt = ST_RELEASED;
            fin_sel_nxt    = ASEL_ECHO;
          end else begin
            fin_status_nxt = ST_ALLOCATED;
            fin_sel_nxt    = ASEL_ENTRY;
          end
        end else begin
          st_nxt = S_SCAN;
        end
      end
      S_FINISH: begin
        // table updates commit together with the result
        if (!out_valid_r || out_ready) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = fin_status_r;
          cmd.res_sel    = fin_sel_r;
          cmd.append     = fin_append_r;
          cmd.wr_flip    = fin_flip_r;
          out_valid_nxt  = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_valid_r  <= 1'b0;
      fin_status_r <= ST_IGNORED;
      fin_sel_r    <= ASEL_ZERO;
      fin_append_r <= 1'b0;
      fin_flip_r   <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      fin_status_r <= fin_status_nxt;
      fin_sel_r    <= fin_sel_nxt;
      fin_append_r <= fin_append_nxt;
      fin_flip_r   <= fin_flip_nxt;
    end
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && in_valid) |=> (st_r == S_CHECK))
    else $error("request accepted but controller did not move to check");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still pending");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !sts.scan_empty)
    else $error("table read past the oldest entry");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (!sts.full && !sts.oom))
    else $error("block appended without room");

  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

FILE: hdl/first_fit_block_allocator.sv
// First-fit block allocator with a table of up to MAX_BLOCKS block records.
// in_req carries one request: mode 0 allocates request_size bytes, mode 1
// releases the block whose user address is release_address. out_rsp returns
// exactly one result per request: user_address and a status code.
// cfg_we/cfg_index/cfg_data write heap_start (index 0) or heap_limit (index 1);
// write only while no request is in flight.
// A request is taken only when the controller is idle. The search reads one
// entry at a time from the table memory and tests it, newest first, until an
// entry matches or the table is exhausted. Zero-size and null requests finish
// without a search. The next request can be taken at the same edge as the
// earliest result handshake. A finished result sits in the output register;
// the next request is accepted while it waits. If the receiver stalls, the
// following request completes its search and then holds in the controller
// until the output register frees up.
// Reset (synchronous, rst_n low) empties the table, loads heap_start and
// heap_limit with their defaults and sets the break to heap_start. No
// clearing pass is needed.
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDRESS_BITS = ffba_pkg::DEF_ADDRESS_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ffba_req_if.sink                    in_req,
  ffba_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0] cfg_data
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffba_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_mode         (in_req.mode),
    .req_size         (in_req.request_size),
    .req_addr         (in_req.release_address),
    .res_user_address (out_rsp.user_address),
    .res_status       (out_rsp.status)
  );

endmodule

`default_nettype wire
